// ===== rtl/thi_pkg.sv =====
// Shared constants, field widths and controller/datapath interface types
// for the timestamped history interpolator. No dependencies.
package thi_pkg;

    localparam int HISTORY_DEPTH = 512;
    localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

    localparam int STAMP_W = 48;
    localparam int FOCAL_W = 12;
    localparam int APER_W  = 10;
    localparam int FOCUS_W = 16;
    localparam int VAL_W   = 16;               // widest lens value
    localparam int PROD_W  = VAL_W + STAMP_W;  // difference times elapsed time
    localparam int ENTRY_W = STAMP_W + FOCAL_W + APER_W + FOCUS_W;

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 40;

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    localparam logic [1:0] FLD_FOCAL = 2'd0;
    localparam logic [1:0] FLD_APER  = 2'd1;
    localparam logic [1:0] FLD_FOCUS = 2'd2;

    typedef struct packed {
        logic       wr;          // write the accepted record
        logic       load_query;  // latch query time, restart the walk
        logic       walk_adv;    // keep current entry as newer bracket, step older
        logic       take_cur;    // result is the current entry
        logic       take_empty;  // result is the empty-history answer
        logic       mul_init;    // load operands for one field
        logic       mul_step;
        logic       div_init;
        logic       div_step;
        logic       fin_field;   // write the interpolated field into the result
        logic       load_out;    // move the result into the output register
        logic [1:0] field;
    } thi_cmd_t;

    typedef struct packed {
        logic empty;        // nothing ever recorded
        logic cur_older;    // current entry time is below query time
        logic age_zero;
        logic age_last;     // current entry is the oldest valid one
        logic out_blocked;  // output register still holds an untaken word
    } thi_sts_t;

endpackage

// ===== rtl/timestamped_history_interpolator_core.sv =====
// Top level of the timestamped history interpolator: stream ports, controller
// and datapath. Depends on thi_pkg, thi_ctrl and thi_dp.
//
// The block keeps the last HISTORY_DEPTH (512) timestamped lens settings in a
// ring memory. A record word (tuser = 0) is written in the cycle it is
// accepted and gives no output word; the block is ready again the next cycle.
// A query word (tuser = 1) walks from the newest entry toward the oldest,
// one memory read (S_RD) and one compare (S_CMP) per entry. If the walk
// stops between two entries, each of the three values goes through one
// shared shift-add multiplier and one restoring divider. The result sits in
// an output register, so a new word is taken while the last result waits;
// a query waits for the output register to free up before finishing. An
// empty history answers with zero values and the empty flag set.
module timestamped_history_interpolator_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // stamp[47:0], focal_mm_in[59:48], aperture_tenths_in[69:60],
    // focus_pos_in[85:70], zero fill
    input  logic [thi_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // kind
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // focal_mm_out[11:0], aperture_tenths_out[21:12], focus_pos_out[37:22],
    // zero fill
    output logic [thi_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // history_empty
    output logic                             m_axis_tuser
);
    import thi_pkg::*;

    thi_cmd_t           cmd;
    thi_sts_t           sts;
    logic [FOCAL_W-1:0] out_focal;
    logic [APER_W-1:0]  out_aper;
    logic [FOCUS_W-1:0] out_focus;

    thi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_kind  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    thi_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_stamp  (s_axis_tdata[STAMP_W-1:0]),
        .in_focal  (s_axis_tdata[STAMP_W +: FOCAL_W]),
        .in_aper   (s_axis_tdata[STAMP_W + FOCAL_W +: APER_W]),
        .in_focus  (s_axis_tdata[STAMP_W + FOCAL_W + APER_W +: FOCUS_W]),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_focal (out_focal),
        .out_aper  (out_aper),
        .out_focus (out_focus),
        .out_empty (m_axis_tuser)
    );

    // Pack the result word, zero fill to whole bytes
    assign m_axis_tdata = {(OUT_DATA_W - FOCAL_W - APER_W - FOCUS_W)'(0),
                           out_focus, out_aper, out_focal};

`ifndef SYNTHESIS
    // An empty-history answer carries zero values.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("empty-history result with nonzero values");

    // A query makes the block busy in the cycle after it is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_QUERY)
        |=> !s_axis_tready)
        else $error("query accepted without going busy");

    // A record is written at once and the block stays ready.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_RECORD)
        |=> s_axis_tready)
        else $error("record left the block busy");
`endif

endmodule

// ===== rtl/thi_ctrl.sv =====
// Controller state machine: walks the history and sequences the shared
// multiply and divide steps. Depends on thi_pkg.
module thi_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_kind,
    output logic              in_ready,
    input  thi_pkg::thi_sts_t sts,
    output thi_pkg::thi_cmd_t cmd
);
    import thi_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_CMP  = 4'd2;
    localparam logic [3:0] S_INIT = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_DIVI = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    localparam int STEP_W = $clog2(VAL_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(VAL_W - 1);

    logic [3:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [1:0]        field_reg, field_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            field_reg <= FLD_FOCAL;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            field_reg <= field_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        field_next = field_reg;
        cmd        = '0;
        cmd.field  = field_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_kind == KIND_RECORD)
                begin
                    cmd.wr = 1'b1;
                end
                else if (in_valid)
                begin
                    cmd.load_query = 1'b1;
                    if (sts.empty)
                    begin
                        cmd.take_empty = 1'b1;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (sts.cur_older && !sts.age_zero)
                begin
                    field_next = FLD_FOCAL;
                    state_next = S_INIT;
                end
                else if (sts.cur_older || sts.age_last)
                begin
                    cmd.take_cur = 1'b1;
                    state_next   = S_OUT;
                end
                else
                begin
                    cmd.walk_adv = 1'b1;
                    state_next   = S_RD;
                end
            end
            S_INIT:
            begin
                cmd.mul_init = 1'b1;
                step_next    = '0;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = S_DIVI;
                end
            end
            S_DIVI:
            begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.fin_field = 1'b1;
                if (field_reg == FLD_FOCUS)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    field_next = field_reg + 1'b1;
                    state_next = S_INIT;
                end
            end
            S_OUT:
            begin
                if (!sts.out_blocked)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/thi_dp.sv =====
// Datapath: history memory, walk registers, bit-serial multiply and
// restoring divide, result and output registers. Depends on thi_pkg.
module thi_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [thi_pkg::STAMP_W-1:0] in_stamp,
    input  logic [thi_pkg::FOCAL_W-1:0] in_focal,
    input  logic [thi_pkg::APER_W-1:0]  in_aper,
    input  logic [thi_pkg::FOCUS_W-1:0] in_focus,
    input  thi_pkg::thi_cmd_t           cmd,
    output thi_pkg::thi_sts_t           sts,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [thi_pkg::FOCAL_W-1:0] out_focal,
    output logic [thi_pkg::APER_W-1:0]  out_aper,
    output logic [thi_pkg::FOCUS_W-1:0] out_focus,
    output logic                        out_empty
);
    import thi_pkg::*;

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HISTORY_DEPTH - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(HISTORY_DEPTH);
    localparam logic [SLOT_W:0]   DEPTH_X   = (SLOT_W + 1)'(HISTORY_DEPTH);

    logic [ENTRY_W-1:0] mem [HISTORY_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [ENTRY_W-1:0] prev_reg;

    logic [SLOT_W-1:0]  newest_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [SLOT_W-1:0]  age_reg;
    logic [STAMP_W-1:0] qtime_reg;

    logic [SLOT_W-1:0]  wr_slot;
    logic [SLOT_W:0]    rd_diff;
    logic [SLOT_W-1:0]  rd_slot;

    logic [STAMP_W-1:0] cur_time, prev_time;
    logic [VAL_W-1:0]   vs, ve;

    logic [STAMP_W-1:0] part_reg, span_reg, rem_reg;
    logic [VAL_W-1:0]   mdiff_reg, vs_reg, quo_reg, dvd_reg;
    logic               neg_reg;
    logic [PROD_W-1:0]  acc_reg;
    logic [STAMP_W:0]   rem_wide;
    logic               div_ge;
    logic [VAL_W-1:0]   fld_val;

    logic [FOCAL_W-1:0] res_focal_reg;
    logic [APER_W-1:0]  res_aper_reg;
    logic [FOCUS_W-1:0] res_focus_reg;
    logic               res_empty_reg;
    logic               out_valid_reg;

    // Entry layout from the lowest bit: stamp, focal, aperture, focus.
    function automatic logic [VAL_W-1:0] field_of(input logic [ENTRY_W-1:0] e,
                                                  input logic [1:0] f);
        logic [VAL_W-1:0] v;
        case (f)
            FLD_FOCAL: v = VAL_W'(e[STAMP_W +: FOCAL_W]);
            FLD_APER:  v = VAL_W'(e[STAMP_W + FOCAL_W +: APER_W]);
            default:   v = e[STAMP_W + FOCAL_W + APER_W +: FOCUS_W];
        endcase
        return v;
    endfunction

    assign wr_slot  = (newest_reg == SLOT_LAST) ? '0 : newest_reg + 1'b1;
    assign rd_diff  = ({1'b0, newest_reg} >= {1'b0, age_reg})
                    ? {1'b0, newest_reg} - {1'b0, age_reg}
                    : {1'b0, newest_reg} + DEPTH_X - {1'b0, age_reg};
    assign rd_slot  = rd_diff[SLOT_W-1:0];

    assign cur_time  = rd_data_reg[STAMP_W-1:0];
    assign prev_time = prev_reg[STAMP_W-1:0];
    assign vs        = field_of(rd_data_reg, cmd.field);
    assign ve        = field_of(prev_reg, cmd.field);

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[wr_slot] <= {in_focus, in_aper, in_focal, in_stamp};
        end
        rd_data_reg <= mem[rd_slot];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            newest_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr)
            begin
                newest_reg <= wr_slot;
                if (count_reg != CNT_FULL)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Walk and arithmetic registers
    assign rem_wide = {rem_reg, dvd_reg[VAL_W-1]};
    assign div_ge   = rem_wide >= {1'b0, span_reg};
    assign fld_val  = neg_reg ? vs_reg - quo_reg - VAL_W'(rem_reg != '0)
                              : vs_reg + quo_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            qtime_reg <= in_stamp;
            age_reg   <= '0;
        end
        if (cmd.walk_adv)
        begin
            prev_reg <= rd_data_reg;
            age_reg  <= age_reg + 1'b1;
        end
        if (cmd.mul_init)
        begin
            part_reg  <= qtime_reg - cur_time;
            span_reg  <= prev_time - cur_time;
            neg_reg   <= ve < vs;
            mdiff_reg <= (ve < vs) ? vs - ve : ve - vs;
            vs_reg    <= vs;
            acc_reg   <= '0;
        end
        if (cmd.mul_step)
        begin
            acc_reg   <= {acc_reg[PROD_W-2:0], 1'b0}
                       + (mdiff_reg[VAL_W-1] ? PROD_W'(part_reg) : '0);
            mdiff_reg <= {mdiff_reg[VAL_W-2:0], 1'b0};
        end
        // The quotient fits in VAL_W bits, so the upper product bits start
        // out below the divisor.
        if (cmd.div_init)
        begin
            rem_reg <= acc_reg[PROD_W-1:VAL_W];
            dvd_reg <= acc_reg[VAL_W-1:0];
            quo_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= div_ge ? STAMP_W'(rem_wide - {1'b0, span_reg})
                              : rem_wide[STAMP_W-1:0];
            quo_reg <= {quo_reg[VAL_W-2:0], div_ge};
            dvd_reg <= {dvd_reg[VAL_W-2:0], 1'b0};
        end
        if (cmd.take_empty)
        begin
            res_focal_reg <= '0;
            res_aper_reg  <= '0;
            res_focus_reg <= '0;
            res_empty_reg <= 1'b1;
        end
        if (cmd.take_cur)
        begin
            res_focal_reg <= rd_data_reg[STAMP_W +: FOCAL_W];
            res_aper_reg  <= rd_data_reg[STAMP_W + FOCAL_W +: APER_W];
            res_focus_reg <= rd_data_reg[STAMP_W + FOCAL_W + APER_W +: FOCUS_W];
            res_empty_reg <= 1'b0;
        end
        if (cmd.fin_field)
        begin
            res_empty_reg <= 1'b0;
            case (cmd.field)
                FLD_FOCAL: res_focal_reg <= fld_val[FOCAL_W-1:0];
                FLD_APER:  res_aper_reg  <= fld_val[APER_W-1:0];
                default:   res_focus_reg <= fld_val;
            endcase
        end
        if (cmd.load_out)
        begin
            out_focal <= res_focal_reg;
            out_aper  <= res_aper_reg;
            out_focus <= res_focus_reg;
            out_empty <= res_empty_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign sts.empty       = (count_reg == '0);
    assign sts.cur_older   = cur_time < qtime_reg;
    assign sts.age_zero    = (age_reg == '0);
    assign sts.age_last    = (CNT_W'(age_reg) + 1'b1 == count_reg);
    assign sts.out_blocked = out_valid_reg && !out_ready;

endmodule

// ===== verif/timestamped_history_interpolator_core_tb.sv =====
// Testbench for the timestamped history interpolator: drives record and query
// words, predicts each result from its own history model and checks it.
// Depends on thi_pkg and timestamped_history_interpolator_core.
module timestamped_history_interpolator_core_tb;
    import thi_pkg::*;

    localparam int  DEPTH     = HISTORY_DEPTH;
    localparam longint LIMIT  = 64'd4000000;

    typedef struct packed {
        logic [FOCAL_W-1:0] focal;
        logic [APER_W-1:0]  aper;
        logic [FOCUS_W-1:0] focus;
        logic               empty;
    } lens_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata;
    logic s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic m_axis_tuser;

    // shadow history
    logic [STAMP_W-1:0] hist_time [DEPTH];
    logic [FOCAL_W-1:0] hist_focal [DEPTH];
    logic [APER_W-1:0]  hist_aper [DEPTH];
    logic [FOCUS_W-1:0] hist_focus [DEPTH];
    int unsigned newest;
    int unsigned filled;
    logic [STAMP_W-1:0] last_stamp;

    lens_t  pending_answers[$];
    int     errors;
    int     answers_seen;
    int     queries_sent;
    int     records_sent;
    longint cycle_count;
    bit     hold_off;
    int     burst_left;

    timestamped_history_interpolator_core DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int unsigned slot_at(int unsigned age);
        return (newest + DEPTH - (age % DEPTH)) % DEPTH;
    endfunction

    // exact linear blend, rounded down to its floor
    function automatic logic [FOCUS_W-1:0] blend(logic [FOCUS_W-1:0] vs,
        logic [FOCUS_W-1:0] ve, logic [STAMP_W-1:0] ts, logic [STAMP_W-1:0] te,
        logic [STAMP_W-1:0] t);
        logic [PROD_W+1:0] num;
        logic [PROD_W+1:0] span;
        num  = {2'b0, vs} * (te - t) + {2'b0, ve} * (t - ts);
        span = (PROD_W + 2)'(te - ts);
        return FOCUS_W'(num / span);
    endfunction

    function automatic lens_t lens_at(logic [STAMP_W-1:0] t);
        lens_t r;
        int unsigned age;
        int unsigned so;
        int unsigned se;
        r = '0;
        if (filled == 0)
        begin
            r.empty = 1'b1;
            return r;
        end
        age = 0;
        while (age < filled && hist_time[slot_at(age)] >= t)
            age++;
        if (age == 0 || age == filled)
        begin
            so = slot_at(age == 0 ? 0 : filled - 1);
            r.focal = hist_focal[so];
            r.aper  = hist_aper[so];
            r.focus = hist_focus[so];
            return r;
        end
        so = slot_at(age);
        se = slot_at(age - 1);
        r.focal = FOCAL_W'(blend(FOCUS_W'(hist_focal[so]), FOCUS_W'(hist_focal[se]),
                                 hist_time[so], hist_time[se], t));
        r.aper  = APER_W'(blend(FOCUS_W'(hist_aper[so]), FOCUS_W'(hist_aper[se]),
                                hist_time[so], hist_time[se], t));
        r.focus = blend(hist_focus[so], hist_focus[se], hist_time[so], hist_time[se], t);
        return r;
    endfunction

    // offer one word, wait for it to be taken, then log a record in the shadow history or queue a query's prediction
    task automatic send_word(logic kind, logic [STAMP_W-1:0] stamp,
        logic [FOCAL_W-1:0] focal, logic [APER_W-1:0] aper, logic [FOCUS_W-1:0] focus);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
        end
        else
            burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {2'b0, focus, aper, focal, stamp};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        if (kind == KIND_RECORD)
        begin
            newest = (newest + 1) % DEPTH;
            hist_time[newest]  = stamp;
            hist_focal[newest] = focal;
            hist_aper[newest]  = aper;
            hist_focus[newest] = focus;
            if (filled < DEPTH) filled++;
            last_stamp = stamp;
            records_sent++;
        end
        else
        begin
            pending_answers = {pending_answers, lens_at(stamp)};
            queries_sent++;
        end
        @(negedge clk);
    endtask

    task automatic record_at(logic [STAMP_W-1:0] stamp);
        send_word(KIND_RECORD, stamp, FOCAL_W'($urandom), APER_W'($urandom),
                  FOCUS_W'($urandom));
    endtask

    task automatic query_at(logic [STAMP_W-1:0] stamp);
        send_word(KIND_QUERY, stamp, FOCAL_W'($urandom), APER_W'($urandom),
                  FOCUS_W'($urandom));
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(negedge clk);
    endtask

    function automatic logic [STAMP_W-1:0] rand_stamp();
        return STAMP_W'({$urandom, $urandom});
    endfunction

    // empty history, then field extremes and every bracket case
    task automatic test_directed;
        query_at('0);
        query_at({STAMP_W{1'b1}});
        send_word(KIND_RECORD, 48'd100, '0, '0, '0);
        query_at(48'd100);          // all newer or equal: oldest
        query_at(48'd101);          // newest already older
        send_word(KIND_RECORD, 48'd1100, '1, '1, '1);
        query_at(48'd600);          // rising blend
        query_at(48'd1100);         // equal to newest
        query_at(48'd101);
        send_word(KIND_RECORD, 48'd1103, '0, '0, '0);
        query_at(48'd1101);         // falling blend, truncation
        query_at(48'd1102);
        send_word(KIND_RECORD, {STAMP_W{1'b1}}, 12'hAAA, 10'h155, 16'hAAAA);
        query_at({STAMP_W{1'b1}} - 1);
        query_at(48'd50);
        send_word(KIND_RECORD, 48'd0, 12'h555, 10'h2AA, 16'h5555);
        query_at(48'd1);
        drain();
    endtask

    // fill past depth so the ring wraps, query deep in history
    task automatic test_wrap;
        logic [STAMP_W-1:0] base;
        base = 48'h1000;
        for (int i = 0; i < DEPTH + 40; i++)
        begin
            base = base + $urandom_range(1, 500);
            record_at(base);
            if ($urandom_range(0, 49) == 0) query_at(base - $urandom_range(0, 20000));
        end
        query_at(48'h1000);         // older than every surviving entry
        query_at(base + 1);
        drain();
    endtask

    // mostly monotonic records with random queries; some disordered noise
    task automatic test_random;
        for (int i = 0; i < 400; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: query_at(rand_stamp());
                    1: query_at(last_stamp + $urandom_range(0, 2));
                    default: query_at(last_stamp - $urandom_range(0, 4000));
                endcase
            end
            else if ($urandom_range(0, 15) == 0)
                record_at(rand_stamp());
            else
                record_at(last_stamp + $urandom_range(0, 300));
        end
        drain();
    endtask

    // receiver holds off while queries pile up behind the output register
    task automatic test_backpressure;
        hold_off = 1'b1;
        for (int i = 0; i < 6; i++)
            query_at(last_stamp - $urandom_range(0, 3000));
        for (int i = 0; i < 4; i++)
            record_at(last_stamp + $urandom_range(1, 50));
        hold_off = 1'b0;
        drain();
    endtask

    // receiver stall pattern, plus the long hold-off when asked
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                m_axis_tready <= 1'b0;
                repeat (3000) @(negedge clk);
                // release and let the stalled sender finish
                m_axis_tready <= 1'b1;
                wait (!hold_off);
            end
            else if (cycle_count % 700 < 200)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 2) != 0);
        end
    end

    // check each accepted result against the oldest prediction
    always @(posedge clk)
    begin
        lens_t got;
        lens_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.focal = m_axis_tdata[FOCAL_W-1:0];
            got.aper  = m_axis_tdata[FOCAL_W +: APER_W];
            got.focus = m_axis_tdata[FOCAL_W + APER_W +: FOCUS_W];
            got.empty = m_axis_tuser;
            answers_seen++;
            if (pending_answers.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (got.focal !== want.focal)
                begin
                    $display("%0t: focal exp %0d got %0d", $time, want.focal, got.focal);
                    errors++;
                end
                if (got.aper !== want.aper)
                begin
                    $display("%0t: aperture exp %0d got %0d", $time, want.aper, got.aper);
                    errors++;
                end
                if (got.focus !== want.focus)
                begin
                    $display("%0t: focus exp %0d got %0d", $time, want.focus, got.focus);
                    errors++;
                end
                if (got.empty !== want.empty)
                begin
                    $display("%0t: empty exp %0b got %0b", $time, want.empty, got.empty);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("timestamped_history_interpolator_core_tb: errors");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        newest = 0; filled = 0; last_stamp = 48'd100000;
        errors = 0; answers_seen = 0; queries_sent = 0; records_sent = 0;
        cycle_count = 0; hold_off = 1'b0; burst_left = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_backpressure();
        test_random();
        test_wrap();
        test_backpressure();
        repeat (2 * DEPTH + 200) @(negedge clk);
        $display("Covered %0d records and %0d queries, %0d results checked,",
            records_sent, queries_sent, answers_seen);
        $display("including empty, edge, wrap and long-stall cases.");
        if (errors == 0 && pending_answers.size() == 0)
            $display("timestamped_history_interpolator_core_tb: clean");
        else
            $display("timestamped_history_interpolator_core_tb: errors");
        $finish;
    end
endmodule
